@@ hw/rtl/byte_stuffed_link_framer_macros.svh @@
// ----------------------------------------------------------------------------
// byte_stuffed_link_framer_macros.svh
// Assertion macros shared by the framer modules.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_LINK_FRAMER_MACROS_SVH
`define BYTE_STUFFED_LINK_FRAMER_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BSF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// next-cycle implication
`define BSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

@@ hw/rtl/bsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bsf_pkg
// Codes, line characters and the job word shared by the framer modules.
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam logic [2:0] OP_LINE_BYTE = 3'd0;
    localparam logic [2:0] OP_SEND_BYTE = 3'd1;
    localparam logic [2:0] OP_CLOSE     = 3'd2;
    localparam logic [2:0] OP_HOST_READ = 3'd3;
    localparam logic [2:0] OP_FLOW_OFF  = 3'd4;
    localparam logic [2:0] OP_FLOW_ON   = 3'd5;

    localparam logic [2:0] KIND_LINE    = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_EOF     = 3'd2;
    localparam logic [2:0] KIND_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_REFUSED = 3'd4;

    localparam logic [7:0] CH_DELIM = 8'h7e;
    localparam logic [7:0] CH_XON   = 8'h11;
    localparam logic [7:0] CH_XOFF  = 8'h13;
    localparam logic [7:0] CH_ESC   = 8'h7d;

    typedef struct packed {
        logic [2:0] kind_first;
        logic [7:0] val_first;
        logic       use_mem;    // first value comes from the queue read port
        logic       two;        // escaped send: ESC then val_second
        logic [7:0] val_second;
        logic       peer;
    } job_t;

    function automatic logic is_special(input logic [7:0] b);
        return (b == CH_DELIM) || (b == CH_XON) || (b == CH_XOFF) || (b == CH_ESC);
    endfunction

endpackage

@@ hw/rtl/bsf_ram.sv @@
// ----------------------------------------------------------------------------
// bsf_ram
// Receive queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bsf_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bsf_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsf_ctrl
// Decodes one word, updates link flags and ring pointers, drives the queue
// ports and builds the job for the output stage.
// ----------------------------------------------------------------------------
`include "byte_stuffed_link_framer_macros.svh"

module bsf_ctrl import bsf_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [2:0]    op,
    input  logic [7:0]    data,
    output job_t          job,
    output logic          job_valid,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr
);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          esc_reg, esc_next;
    logic          fes_reg, fes_next;
    logic          send_reg, send_next;
    logic          recv_reg, recv_next;
    logic          push, pop;
    logic [AW-1:0] head_inc, tail_inc;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign head_inc = ring_next(head_reg);
    assign tail_inc = ring_next(tail_reg);

    always_comb begin
        esc_next  = esc_reg;
        fes_next  = fes_reg;
        send_next = send_reg;
        recv_next = recv_reg;
        push      = 1'b0;
        pop       = 1'b0;
        job_valid = 1'b0;
        job.kind_first = KIND_LINE;
        job.val_first  = 8'h00;
        job.use_mem    = 1'b0;
        job.two        = 1'b0;
        job.val_second = data;
        job.peer       = send_reg;
        case (op)
            OP_LINE_BYTE: begin
                if (esc_reg) begin
                    push     = 1'b1;
                    esc_next = 1'b0;
                end else if (data == CH_ESC) begin
                    esc_next = 1'b1;
                end else if (data == CH_XOFF) begin
                    send_next = 1'b0;
                end else if (data == CH_XON) begin
                    send_next = 1'b1;
                end else if (data == CH_DELIM) begin
                    fes_next = 1'b1;
                end else begin
                    push = 1'b1;
                end
            end
            OP_SEND_BYTE: begin
                job_valid = 1'b1;
                if (!send_reg) begin
                    job.kind_first = KIND_REFUSED;
                end else if (is_special(data)) begin
                    job.val_first = CH_ESC;
                    job.two       = 1'b1;
                end else begin
                    job.val_first = data;
                end
            end
            OP_CLOSE: begin
                job_valid = 1'b1;
                if (!send_reg) begin
                    job.kind_first = KIND_REFUSED;
                end else begin
                    job.val_first = CH_DELIM;
                end
            end
            OP_HOST_READ: begin
                job_valid = 1'b1;
                if (!recv_reg) begin
                    job.kind_first = KIND_REFUSED;
                end else if (head_reg != tail_reg) begin
                    job.kind_first = KIND_DATA;
                    job.use_mem    = 1'b1;
                    pop            = 1'b1;
                end else if (fes_reg) begin
                    job.kind_first = KIND_EOF;
                    fes_next       = 1'b0;
                end else begin
                    job.kind_first = KIND_EMPTY;
                end
            end
            OP_FLOW_OFF: begin
                job_valid     = 1'b1;
                recv_next     = 1'b0;
                job.val_first = CH_XOFF;
            end
            OP_FLOW_ON: begin
                job_valid     = 1'b1;
                recv_next     = 1'b1;
                job.val_first = CH_XON;
            end
            default: begin
            end
        endcase
    end

    // push overwrites the oldest byte when the ring is full
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (push) begin
            head_next = head_inc;
            if (head_inc == tail_reg) begin
                tail_next = tail_inc;
            end
        end
        if (pop) begin
            tail_next = tail_inc;
        end
    end

    assign wr_en   = accept && push;
    assign wr_addr = head_reg;
    assign wr_data = data;
    assign rd_en   = accept && pop;
    assign rd_addr = tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            esc_reg  <= 1'b0;
            fes_reg  <= 1'b0;
            send_reg <= 1'b1;
            recv_reg <= 1'b1;
        end else if (accept) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            esc_reg  <= esc_next;
            fes_reg  <= fes_next;
            send_reg <= send_next;
            recv_reg <= recv_next;
        end
    end

    `BSF_ASSERT_NEXT(a_push_not_empty, wr_en, head_reg != tail_reg)
    `BSF_ASSERT_IMPL(a_pop_not_empty, rd_en, head_reg != tail_reg)
    `BSF_ASSERT_IMPL(a_ptr_range, 1'b1,
        (head_reg <= AW'(DEPTH - 1)) && (tail_reg <= AW'(DEPTH - 1)))

endmodule

@@ hw/rtl/bsf_out.sv @@
// ----------------------------------------------------------------------------
// bsf_out
// Holds one job, emits its one or two result words into the output register.
// ----------------------------------------------------------------------------
`include "byte_stuffed_link_framer_macros.svh"

module bsf_out import bsf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_load,
    input  job_t       job_in,
    input  logic [7:0] rd_data,
    output logic       in_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_value,
    output logic       m_last,
    output logic       m_peer
);

    logic       hold_valid_reg, hold_valid_next;
    job_t       hold_job_reg, hold_job_next;
    logic       phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_kind_reg, m_kind_next;
    logic [7:0] m_value_reg, m_value_next;
    logic       m_last_reg, m_last_next;
    logic       m_peer_reg, m_peer_next;
    logic       out_load, emit, done;

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = hold_valid_reg && out_load;
    assign done     = emit && (!hold_job_reg.two || phase_reg);
    assign in_ready = !hold_valid_reg || done;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_job_next   = hold_job_reg;
        phase_next      = phase_reg;
        if (job_load) begin
            hold_valid_next = 1'b1;
            hold_job_next   = job_in;
            phase_next      = 1'b0;
        end else if (done) begin
            hold_valid_next = 1'b0;
        end else if (emit) begin
            phase_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        m_peer_next  = m_peer_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_peer_next  = hold_job_reg.peer;
            m_last_next  = !hold_job_reg.two || phase_reg;
            if (phase_reg) begin
                m_kind_next  = KIND_LINE;
                m_value_next = hold_job_reg.val_second;
            end else begin
                m_kind_next  = hold_job_reg.kind_first;
                m_value_next = hold_job_reg.use_mem ? rd_data : hold_job_reg.val_first;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_job_reg <= hold_job_next;
        m_kind_reg   <= m_kind_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
        m_peer_reg   <= m_peer_next;
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;
    assign m_peer  = m_peer_reg;

    `BSF_ASSERT_IMPL(a_escape_blocks_input,
        hold_valid_reg && hold_job_reg.two && !phase_reg, !in_ready)
    `BSF_ASSERT_IMPL(a_single_kinds_last,
        m_valid_reg && (m_kind_reg != KIND_LINE), m_last_reg)
    `BSF_ASSERT_IMPL(a_status_value_zero,
        m_valid_reg && ((m_kind_reg == KIND_EOF) || (m_kind_reg == KIND_EMPTY) ||
        (m_kind_reg == KIND_REFUSED)), m_value_reg == 8'h00)

endmodule

@@ hw/rtl/byte_stuffed_link_framer.sv @@
// ----------------------------------------------------------------------------
// byte_stuffed_link_framer
// Byte-stuffed link framer with XON/XOFF flow control and a receive ring.
//
//   channel   dir  tuser              tdata
//   s_        in   [2:0] operation    [7:0] data
//   m_        out  [2:0] kind         [7:0] value, [8] peer allow; tlast = last
//
// One word per cycle while the output is not stalled; an escaped send byte
// gives two result words and holds the input until the second is out. Queue
// reads use the registered ring read port. No clearing pass after reset;
// the ring memory is not reset. A stalled output backs up through a single
// job register, and the next word is taken as the current job finishes.
// ----------------------------------------------------------------------------
module byte_stuffed_link_framer import bsf_pkg::*; #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value, [8] peer_allows_send, zero fill
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic          accept;
    job_t          job;
    logic          job_valid;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    logic          m_peer;
    logic [7:0]    m_value;

    assign accept = s_tvalid && s_tready;

    bsf_ctrl #(
        .DEPTH(QUEUE_DEPTH),
        .AW   (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .op       (s_tuser),
        .data     (s_tdata),
        .job      (job),
        .job_valid(job_valid),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    bsf_ram #(
        .DEPTH(QUEUE_DEPTH),
        .AW   (AW)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    bsf_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .job_load(accept && job_valid),
        .job_in  (job),
        .rd_data (rd_data),
        .in_ready(s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_kind  (m_tuser),
        .m_value (m_value),
        .m_last  (m_tlast),
        .m_peer  (m_peer)
    );

    assign m_tdata = {7'b0000000, m_peer, m_value};

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_stuffed_link_framer. Line, send, close, read
// and flow words are streamed in with random gaps and output stalls. A
// behavioral copy of the framer (receive ring, escape and flow state)
// predicts every output word, and each output word is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import bsf_pkg::*;

    localparam int RING_DEPTH = 256;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        bit         drain;  // hold off until all output words are in
    } link_cmd_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
        logic       peer;
    } framer_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    link_cmd_t    cmd_queue [$];
    framer_word_t due_words [$];
    int           mismatches = 0;
    int           stim_count = 0;

    logic [7:0] rx_ring [RING_DEPTH];
    int         ring_head = 0;
    int         ring_tail = 0;
    bit         esc_armed = 0;
    bit         eof_seen  = 0;
    bit         peer_ok   = 1;
    bit         host_ok   = 1;

    bit s_fired = 0;
    int s_gap   = 0;
    int r_gap   = 0;
    bit s_quiet = 0;
    bit r_quiet = 0;

    byte_stuffed_link_framer #(.QUEUE_DEPTH(RING_DEPTH)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void ring_store(input logic [7:0] b);
        int nh;
        nh = (ring_head + 1) % RING_DEPTH;
        rx_ring[ring_head] = b;
        ring_head = nh;
        if (nh == ring_tail) begin
            ring_tail = (ring_tail + 1) % RING_DEPTH;
        end
    endfunction

    task automatic framer_predict(input logic [2:0] op, input logic [7:0] data);
        logic [2:0]   k [2];
        logic [7:0]   v [2];
        int           n;
        framer_word_t w;
        n = 0;
        case (op)
            OP_LINE_BYTE: begin
                if (esc_armed) begin
                    ring_store(data);
                    esc_armed = 0;
                end else if (data == CH_ESC) begin
                    esc_armed = 1;
                end else if (data == CH_XOFF) begin
                    peer_ok = 0;
                end else if (data == CH_XON) begin
                    peer_ok = 1;
                end else if (data == CH_DELIM) begin
                    eof_seen = 1;
                end else begin
                    ring_store(data);
                end
            end
            OP_SEND_BYTE: begin
                if (!peer_ok) begin
                    k[n] = KIND_REFUSED; v[n] = 8'h00; n++;
                end else begin
                    if (data == CH_DELIM || data == CH_XON || data == CH_XOFF
                            || data == CH_ESC) begin
                        k[n] = KIND_LINE; v[n] = CH_ESC; n++;
                    end
                    k[n] = KIND_LINE; v[n] = data; n++;
                end
            end
            OP_CLOSE: begin
                k[n] = peer_ok ? KIND_LINE : KIND_REFUSED;
                v[n] = peer_ok ? CH_DELIM : 8'h00;
                n++;
            end
            OP_HOST_READ: begin
                if (!host_ok) begin
                    k[n] = KIND_REFUSED; v[n] = 8'h00;
                end else if (ring_head != ring_tail) begin
                    k[n] = KIND_DATA; v[n] = rx_ring[ring_tail];
                    ring_tail = (ring_tail + 1) % RING_DEPTH;
                end else if (eof_seen) begin
                    eof_seen = 0;
                    k[n] = KIND_EOF; v[n] = 8'h00;
                end else begin
                    k[n] = KIND_EMPTY; v[n] = 8'h00;
                end
                n++;
            end
            OP_FLOW_OFF: begin
                host_ok = 0;
                k[n] = KIND_LINE; v[n] = CH_XOFF; n++;
            end
            OP_FLOW_ON: begin
                host_ok = 1;
                k[n] = KIND_LINE; v[n] = CH_XON; n++;
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            w.kind  = k[i];
            w.value = v[i];
            w.last  = (i == n - 1);
            w.peer  = peer_ok;
            due_words.push_back(w);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor first, then input acceptance: a word taken at this edge
    // cannot have an output word at the same edge
    always @(posedge aclk) begin
        framer_word_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual kind %0h value %0h",
                             $time, m_tuser, m_tdata[7:0]);
                    mismatches++;
                end else begin
                    want = due_words.pop_front();
                    check_field("kind", 8'(want.kind), 8'(m_tuser));
                    check_field("value", want.value, m_tdata[7:0]);
                    check_field("last", 8'(want.last), 8'(m_tlast));
                    check_field("peer", 8'(want.peer), 8'(m_tdata[8]));
                end
            end
            s_fired = s_tvalid && s_tready;
            if (s_fired) begin
                framer_predict(s_tuser, s_tdata);
                void'(cmd_queue.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        bit calm;
        calm = cmd_queue.size() < 120;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= OP_LINE_BYTE;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) s_quiet = !s_quiet;
            if ($urandom_range(0, 99) == 0) r_quiet = !r_quiet;

            if (s_tvalid && !s_fired) begin
                // word still on offer
            end else if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (cmd_queue[0].drain && due_words.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (!calm && !s_quiet && $urandom_range(0, 5) == 0) begin
                s_gap = $urandom_range(1, 3) - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= cmd_queue[0].data;
                s_tuser  <= cmd_queue[0].op;
            end

            if (r_gap > 0) begin
                r_gap--;
                m_tready <= 1'b0;
            end else if (!calm && !r_quiet && $urandom_range(0, 4) == 0) begin
                r_gap = $urandom_range(1, 3) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(input logic [2:0] op, input logic [7:0] data,
                            input bit drain = 0);
        link_cmd_t c;
        c.op    = op;
        c.data  = data;
        c.drain = drain;
        cmd_queue.push_back(c);
        if (op <= OP_FLOW_ON) stim_count++;
    endtask

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 3))
            0: return CH_DELIM;
            1: return CH_XON;
            2: return CH_XOFF;
            default: return CH_ESC;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CH_DELIM || b == CH_XON || b == CH_XOFF || b == CH_ESC) b ^= 8'h01;
        return b;
    endfunction

    initial begin
        int  n;
        bit  drain;
        bit  flooded;
        logic [7:0] b;

        aresetn  = 1'b0;
        flooded  = 0;

        // directed words
        push_cmd(OP_SEND_BYTE, 8'h00);
        push_cmd(OP_SEND_BYTE, 8'hff);
        push_cmd(OP_SEND_BYTE, CH_DELIM);
        push_cmd(OP_SEND_BYTE, CH_XON);
        push_cmd(OP_SEND_BYTE, CH_XOFF);
        push_cmd(OP_SEND_BYTE, CH_ESC);
        push_cmd(OP_CLOSE, 8'h00);
        push_cmd(OP_HOST_READ, 8'h00);
        push_cmd(OP_LINE_BYTE, 8'h41);
        push_cmd(OP_LINE_BYTE, CH_DELIM);
        push_cmd(OP_HOST_READ, 8'hff);
        push_cmd(OP_HOST_READ, 8'h00);
        push_cmd(OP_HOST_READ, 8'h00);
        push_cmd(OP_LINE_BYTE, CH_ESC);
        push_cmd(OP_LINE_BYTE, CH_DELIM);
        push_cmd(OP_HOST_READ, 8'h00);
        push_cmd(OP_LINE_BYTE, CH_XOFF);
        push_cmd(OP_SEND_BYTE, 8'h55);
        push_cmd(OP_CLOSE, 8'hff);
        push_cmd(OP_LINE_BYTE, CH_XON);
        push_cmd(OP_FLOW_OFF, 8'h00);
        push_cmd(OP_HOST_READ, 8'h00);
        push_cmd(OP_FLOW_ON, 8'h00);
        push_cmd(3'd6, 8'hff);
        push_cmd(3'd7, 8'h00);

        drain = 1;
        while (stim_count < 1125) begin
            if (!flooded && stim_count > 500) begin
                // overrun the ring so the oldest bytes get overwritten
                flooded = 1;
                for (int i = 0; i < 270; i++) push_cmd(OP_LINE_BYTE, pick_plain(), i == 0);
                for (int i = 0; i < 10; i++) push_cmd(OP_HOST_READ, 8'($urandom));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    n = $urandom_range(0, 8);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            push_cmd(OP_LINE_BYTE, CH_ESC, drain && i == 0);
                            b = $urandom_range(0, 1) ? pick_special() : pick_plain();
                            push_cmd(OP_LINE_BYTE, b);
                        end else begin
                            push_cmd(OP_LINE_BYTE, pick_plain(), drain && i == 0);
                        end
                    end
                    push_cmd(OP_LINE_BYTE, CH_DELIM, drain && n == 0);
                    for (int i = 0; i < n + 2; i++) push_cmd(OP_HOST_READ, 8'($urandom));
                end
                4, 5: begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        b = ($urandom_range(0, 3) == 0) ? pick_special() : 8'($urandom);
                        push_cmd(OP_SEND_BYTE, b, drain && i == 0);
                    end
                    push_cmd(OP_CLOSE, 8'($urandom));
                end
                6: begin
                    push_cmd(OP_LINE_BYTE, CH_XOFF, drain);
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) begin
                        push_cmd($urandom_range(0, 1) ? OP_SEND_BYTE : OP_CLOSE, 8'($urandom));
                    end
                    push_cmd(OP_LINE_BYTE, CH_XON);
                end
                7: begin
                    push_cmd(OP_FLOW_OFF, 8'($urandom), drain);
                    n = $urandom_range(1, 2);
                    for (int i = 0; i < n; i++) push_cmd(OP_HOST_READ, 8'($urandom));
                    push_cmd(OP_FLOW_ON, 8'($urandom));
                end
                default: begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        push_cmd(3'($urandom_range(0, 7)), 8'($urandom), drain && i == 0);
                    end
                end
            endcase
            drain = ($urandom_range(0, 7) == 0);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() != 0 || due_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
